// ===== rtl/core/mtg_pkg.sv =====
`default_nettype none

package mtg_pkg;

    // State depth and twist tap
    localparam int unsigned StateDepth = 624;
    localparam int unsigned TapOffset  = 397;
    localparam int unsigned CountWidth = $clog2(StateDepth);

    typedef logic [31:0] t_word;
    typedef logic [CountWidth-1:0] t_count;

    // Seeding generator: x <- LcgMult * x + 1, two steps per word
    localparam t_word LcgMult     = 32'd69069;
    localparam t_word LcgMultSq   = 32'd475559465;  // 69069^2 mod 2^32
    localparam t_word LcgAddSq    = 32'd69070;      // 69069 + 1
    localparam t_word LcgAdd      = 32'd1;
    localparam t_word HighHalf    = 32'hffff0000;
    localparam t_word DefaultSeed = 32'd4357;

    // Twist and temper constants
    localparam t_word TwistXor = 32'h9908b0df;
    localparam t_word TopBit   = 32'h80000000;
    localparam t_word LowBits  = 32'h7fffffff;
    localparam t_word TemperB  = 32'h9d2c5680;
    localparam t_word TemperC  = 32'hefc60000;

    // Request codes
    localparam logic OpDraw = 1'b0;
    localparam logic OpSeed = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_RUN  = 3'b001,
        S_FILL = 3'b010,
        S_DRAW = 3'b100
    } t_state;

    // Seeder control and status
    typedef struct packed {
        logic  start;
        t_word seed;
    } t_seed_ctl;

    typedef struct packed {
        logic active;
        logic last;
    } t_seed_stat;

    function automatic t_word temper(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mtg_cell.sv =====
`default_nettype none

module mtg_cell (
    input  wire logic          i_clk,
    input  wire logic          i_shift,
    input  wire mtg_pkg::t_word i_d,
    output mtg_pkg::t_word     o_q
);

    mtg_pkg::t_word r_word;

    // Take the neighbor's word on every shift, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule

`default_nettype wire

// ===== rtl/core/mtg_seeder.sv =====
`default_nettype none

module mtg_seeder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mtg_pkg::t_seed_ctl i_ctl,
    output mtg_pkg::t_seed_stat    o_stat,
    output mtg_pkg::t_word         o_word
);

    mtg_pkg::t_word  r_x;
    mtg_pkg::t_word  n_x;
    mtg_pkg::t_word  w_x1;
    mtg_pkg::t_count r_cnt;
    logic            r_active;
    logic            w_last;

    // One generator step for the low half, two steps for the next word
    assign w_x1   = mtg_pkg::LcgMult * r_x + mtg_pkg::LcgAdd;
    assign n_x    = mtg_pkg::LcgMultSq * r_x + mtg_pkg::LcgAddSq;
    assign o_word = (r_x & mtg_pkg::HighHalf) | ((w_x1 & mtg_pkg::HighHalf) >> 16);
    assign w_last = r_active && (r_cnt == mtg_pkg::t_count'(mtg_pkg::StateDepth - 1));

    // Advance the generator once per word
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_x <= i_ctl.seed;
        end else if (r_active) begin
            r_x <= n_x;
        end
    end

    // Count words until the chain is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (i_ctl.start) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (r_active) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    assign o_stat.active = r_active;
    assign o_stat.last   = w_last;

endmodule

`default_nettype wire

// ===== rtl/core/mtg_twist.sv =====
`default_nettype none

module mtg_twist (
    input  wire mtg_pkg::t_word i_w0,
    input  wire mtg_pkg::t_word i_w1,
    input  wire mtg_pkg::t_word i_wtap,
    output mtg_pkg::t_word     o_next,
    output mtg_pkg::t_word     o_tempered
);

    mtg_pkg::t_word w_y;
    mtg_pkg::t_word w_mag;

    // Combine top bit of the oldest word with the low bits of the next
    assign w_y    = (i_w0 & mtg_pkg::TopBit) | (i_w1 & mtg_pkg::LowBits);
    assign w_mag  = w_y[0] ? mtg_pkg::TwistXor : '0;
    assign o_next = i_wtap ^ (w_y >> 1) ^ w_mag;

    // Temper the fresh word for output
    assign o_tempered = mtg_pkg::temper(o_next);

endmodule

`default_nettype wire

// ===== rtl/core/mersenne_twister_generator_core.sv =====
// MT19937 generator core with the classic 69069 seeding. The 624-word state
// sits in a chain of word cells; every draw twists the oldest word
// with its neighbor and the tap 397 cells on, shifts the chain by one and
// returns the tempered new word in the cycle after the request, so seeded draws
// are taken one per cycle with busy low. A seed request loads the chain from
// the seeding generator at one word per cycle: busy stays high while it fills
// and no result is returned. A draw requested before any seed first seeds with
// 4357 and then twists, so busy stays high through the fill and the twist,
// and its result is registered from that twist. Each result is shown on
// o_random_word for one cycle with o_valid high and must be taken then;
// the core cannot be stalled.
`default_nettype none

module mersenne_twister_generator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        i_opcode,
    input  wire logic [31:0] i_seed_value,
    output logic             busy,
    output logic             o_valid,
    output logic [31:0]      o_random_word
);

    localparam int unsigned Depth = mtg_pkg::StateDepth;

    mtg_pkg::t_state     r_state;
    mtg_pkg::t_state     n_state;
    logic                r_seeded;
    logic                r_valid;
    mtg_pkg::t_word      r_word;
    mtg_pkg::t_seed_ctl  w_seed_ctl;
    mtg_pkg::t_seed_stat w_seed_stat;
    mtg_pkg::t_word      w_seed_word;
    mtg_pkg::t_word      w_next;
    mtg_pkg::t_word      w_tempered;
    mtg_pkg::t_word      w_tail;
    mtg_pkg::t_word      w_q [Depth];
    logic                w_accept;
    logic                w_draw_step;
    logic                w_shift;

    assign busy     = (r_state != mtg_pkg::S_RUN);
    assign w_accept = start && !busy;

    // Run the draw step on a seeded draw or after a default fill
    assign w_draw_step = (w_accept && (i_opcode == mtg_pkg::OpDraw) && r_seeded)
                      || (r_state == mtg_pkg::S_DRAW);
    assign w_shift     = w_draw_step || w_seed_stat.active;

    // Start the seeder on a seed request or an unseeded draw
    assign w_seed_ctl.start = w_accept
                           && ((i_opcode == mtg_pkg::OpSeed) || !r_seeded);
    assign w_seed_ctl.seed  = (i_opcode == mtg_pkg::OpSeed) ? i_seed_value
                                                            : mtg_pkg::DefaultSeed;

    mtg_seeder u_seeder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_seed_ctl),
        .o_stat  (w_seed_stat),
        .o_word  (w_seed_word)
    );

    mtg_twist u_twist (
        .i_w0       (w_q[0]),
        .i_w1       (w_q[1]),
        .i_wtap     (w_q[mtg_pkg::TapOffset]),
        .o_next     (w_next),
        .o_tempered (w_tempered)
    );

    // Feed the tail from the seeder while filling, from the twist otherwise
    assign w_tail = w_seed_stat.active ? w_seed_word : w_next;

    // Chain of state cells, oldest word in cell zero
    for (genvar g = 0; g < Depth; g++) begin : g_cell
        if (g == Depth - 1) begin : g_tail
            mtg_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_tail),
                .o_q     (w_q[g])
            );
        end else begin : g_body
            mtg_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_q[g+1]),
                .o_q     (w_q[g])
            );
        end
    end

    // Sequence fills and the pending draw
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtg_pkg::S_RUN: begin
                if (w_seed_ctl.start) begin
                    n_state = mtg_pkg::S_FILL;
                end
            end
            mtg_pkg::S_FILL: begin
                if (w_seed_stat.last) begin
                    n_state = r_seeded ? mtg_pkg::S_RUN : mtg_pkg::S_DRAW;
                end
            end
            mtg_pkg::S_DRAW: begin
                n_state = mtg_pkg::S_RUN;
            end
            default: begin
                n_state = mtg_pkg::S_RUN;
            end
        endcase
    end

    // Advance the sequencer; mark seeded on a seed request or after a default fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mtg_pkg::S_RUN;
            r_seeded <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_draw_step;
            if (r_state == mtg_pkg::S_DRAW) begin
                r_seeded <= 1'b1;
            end else if (w_accept && (i_opcode == mtg_pkg::OpSeed)) begin
                r_seeded <= 1'b1;
            end
        end
    end

    // Hold the tempered word for its one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (w_draw_step) begin
            r_word <= w_tempered;
        end
    end

    assign o_valid       = r_valid;
    assign o_random_word = r_word;

    a_fill_matches_seeder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtg_pkg::S_FILL) == w_seed_stat.active)
        else $error("fill state and seeder activity disagree");

    a_no_draw_while_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seed_stat.active |-> !w_draw_step)
        else $error("draw step while the chain is filling");

    a_pending_draw_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtg_pkg::S_DRAW) |-> $past(w_seed_stat.last))
        else $error("pending draw without a completed fill");

    a_seed_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_opcode == mtg_pkg::OpSeed)) |=> !o_valid)
        else $error("result strobe after a seed request");

endmodule

`default_nettype wire
